[sv/sim_pkg.sv]
// sim_pkg: shared constants for the sorted interval membership block
// field widths, function and status codes, default sizes
// no dependencies
`timescale 1ns / 1ps

package sim_pkg;

    localparam int DEF_MAX_INTERVALS = 1024;
    localparam int DEF_MAX_SEQS      = 64;

    localparam int FUNC_W   = 2;
    localparam int SEQ_ID_W = 6;
    localparam int POS_W    = 31;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNSORTED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_CONTIG = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd4;

endpackage

[sv/sim_in_if.sv]
// sim_in_if: request channel of the sorted interval membership block
// valid/ready handshake with the request payload
// depends on sim_pkg
`timescale 1ns / 1ps

interface sim_in_if
    import sim_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SEQ_ID_W-1:0] seq_id;
    logic [POS_W-1:0]    interval_start;
    logic [POS_W-1:0]    interval_end;
    logic                single_position;
    logic [POS_W-1:0]    query_position;

    modport source (
        output valid, func, seq_id, interval_start, interval_end, single_position,
               query_position,
        input  ready
    );

    modport sink (
        input  valid, func, seq_id, interval_start, interval_end, single_position,
               query_position,
        output ready
    );
endinterface

[sv/sim_out_if.sv]
// sim_out_if: response channel of the sorted interval membership block
// valid/ready handshake with the response payload
// depends on sim_pkg
`timescale 1ns / 1ps

interface sim_out_if
    import sim_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [POS_W-1:0]    hit_start;
    logic [POS_W-1:0]    hit_end;
    logic [SLOT_W-1:0]   hit_slot;

    modport source (
        output valid, status, hit, hit_start, hit_end, hit_slot,
        input  ready
    );

    modport sink (
        input  valid, status, hit, hit_start, hit_end, hit_slot,
        output ready
    );
endinterface

[sv/sim_ram.sv]
// sim_ram: generic simple dual port ram, one write and one registered read port
// no reset, contents undefined until written
// no dependencies
`timescale 1ns / 1ps

module sim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[sv/sorted_interval_membership.sv]
// sorted_interval_membership: interval store with per-sequence blocks and a forward cursor
// load, unfound select, query with no block: straight to response; found select: via S_SEL
// query: S_QCMP skips intervals with the cursor, one interval ram read per cycle
// result held until transferred; next request taken the cycle after the response transfer
// rst_n clears control state asynchronously; interval and block rams are not cleared
// depends on sim_pkg, sim_in_if, sim_out_if, sim_ram
`timescale 1ns / 1ps

module sorted_interval_membership
    import sim_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int MAX_SEQS      = DEF_MAX_SEQS
) (
    input  logic      clk,
    input  logic      rst_n,
    sim_in_if.sink    req,
    sim_out_if.source rsp
);
    localparam int IW        = $clog2(MAX_INTERVALS);
    localparam int CW        = $clog2(MAX_INTERVALS + 1);
    localparam int SEQ_SPACE = 2 ** SEQ_ID_W;
    localparam int SEQ_DEPTH = (MAX_SEQS < SEQ_SPACE) ? MAX_SEQS : SEQ_SPACE;
    localparam int SW        = $clog2(SEQ_DEPTH);
    localparam int IVW       = 2 * POS_W;
    localparam int BKW       = IW + CW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_QCMP,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [SEQ_DEPTH-1:0] seen_reg, seen_next;
    logic [CW-1:0]        total_reg, total_next;
    logic                 last_valid_reg, last_valid_next;
    logic [SW-1:0]        last_seq_reg, last_seq_next;
    logic [IW-1:0]        last_base_reg, last_base_next;
    logic [CW-1:0]        last_count_reg, last_count_next;
    logic [POS_W-1:0]     last_lo_reg, last_lo_next;
    logic [POS_W-1:0]     last_hi_reg, last_hi_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [SW-1:0]        cur_seq_reg, cur_seq_next;
    logic [IW-1:0]        cur_base_reg, cur_base_next;
    logic [CW-1:0]        cur_count_reg, cur_count_next;
    logic [CW-1:0]        cursor_reg, cursor_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 hit_reg, hit_next;
    logic [POS_W-1:0]     hit_start_reg, hit_start_next;
    logic [POS_W-1:0]     hit_end_reg, hit_end_next;
    logic [SLOT_W-1:0]    hit_slot_reg, hit_slot_next;

    logic                 iv_we, iv_re;
    logic [IW-1:0]        iv_waddr, iv_raddr;
    logic [IVW-1:0]       iv_wdata, iv_rdata;
    logic [POS_W-1:0]     iv_start, iv_end;
    logic                 bk_we, bk_re;
    logic [BKW-1:0]       bk_wdata, bk_rdata;

    logic [SW-1:0]        seq_idx;
    logic                 seq_ok;
    logic                 fresh;
    logic [POS_W-1:0]     load_hi;
    logic [IW-1:0]        new_base;
    logic [CW-1:0]        new_count;
    logic [CW-1:0]        cursor_rd;
    logic [CW-1:0]        rd_sum;
    logic [CW-1:0]        slot_sum;
    logic [IW-1:0]        slot_idx;
    logic [31:0]          slot_wide;

    assign seq_idx   = req.seq_id[SW-1:0];
    assign seq_ok    = 32'(req.seq_id) < MAX_SEQS;
    assign fresh     = !last_valid_reg || (last_seq_reg != seq_idx);
    assign load_hi   = req.single_position ? req.interval_start : req.interval_end;
    assign new_base  = fresh ? total_reg[IW-1:0] : last_base_reg;
    assign new_count = fresh ? CW'(1) : CW'(last_count_reg + 1'b1);

    assign cursor_rd = (state_reg == S_QCMP) ? CW'(cursor_reg + 1'b1) : cursor_reg;
    assign rd_sum    = CW'(CW'(cur_base_reg) + cursor_rd);
    assign iv_raddr  = rd_sum[IW-1:0];
    assign iv_start  = iv_rdata[IVW-1:POS_W];
    assign iv_end    = iv_rdata[POS_W-1:0];

    assign slot_sum  = CW'(CW'(cur_base_reg) + cursor_reg);
    assign slot_idx  = slot_sum[IW-1:0];
    assign slot_wide = 32'(slot_idx);

    assign iv_waddr  = total_reg[IW-1:0];
    assign iv_wdata  = {req.interval_start, load_hi};
    assign bk_wdata  = {new_base, new_count};

    sim_ram #(
        .WIDTH (IVW),
        .DEPTH (MAX_INTERVALS)
    ) u_iv_ram (
        .clk   (clk),
        .we    (iv_we),
        .waddr (iv_waddr),
        .wdata (iv_wdata),
        .re    (iv_re),
        .raddr (iv_raddr),
        .rdata (iv_rdata)
    );

    sim_ram #(
        .WIDTH (BKW),
        .DEPTH (SEQ_DEPTH)
    ) u_bk_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (seq_idx),
        .wdata (bk_wdata),
        .re    (bk_re),
        .raddr (seq_idx),
        .rdata (bk_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        total_next      = total_reg;
        last_valid_next = last_valid_reg;
        last_seq_next   = last_seq_reg;
        last_base_next  = last_base_reg;
        last_count_next = last_count_reg;
        last_lo_next    = last_lo_reg;
        last_hi_next    = last_hi_reg;
        cur_valid_next  = cur_valid_reg;
        cur_seq_next    = cur_seq_reg;
        cur_base_next   = cur_base_reg;
        cur_count_next  = cur_count_reg;
        cursor_next     = cursor_reg;
        pos_next        = pos_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        hit_start_next  = hit_start_reg;
        hit_end_next    = hit_end_reg;
        hit_slot_next   = hit_slot_reg;
        iv_we           = 1'b0;
        iv_re           = 1'b0;
        bk_we           = 1'b0;
        bk_re           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next    = STAT_OK;
                    hit_next       = 1'b0;
                    hit_start_next = '0;
                    hit_end_next   = '0;
                    hit_slot_next  = '0;
                    state_next     = S_RESP;
                    case (req.func)
                        FUNC_LOAD:
                        begin
                            if (!seq_ok)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else if (fresh && seen_reg[seq_idx])
                            begin
                                status_next = STAT_NOT_CONTIG;
                            end
                            else if (total_reg >= CW'(MAX_INTERVALS))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (!fresh && ((req.interval_start < last_lo_reg) ||
                                     ((req.interval_start == last_lo_reg) &&
                                      (load_hi < last_hi_reg))))
                            begin
                                status_next = STAT_UNSORTED;
                            end
                            else
                            begin
                                iv_we              = 1'b1;
                                bk_we              = 1'b1;
                                seen_next[seq_idx] = 1'b1;
                                total_next         = CW'(total_reg + 1'b1);
                                last_valid_next    = 1'b1;
                                last_seq_next      = seq_idx;
                                last_base_next     = new_base;
                                last_count_next    = new_count;
                                last_lo_next       = req.interval_start;
                                last_hi_next       = load_hi;
                                if (cur_valid_reg && (cur_seq_reg == seq_idx))
                                begin
                                    cur_count_next = new_count;
                                end
                            end
                        end
                        FUNC_SELECT:
                        begin
                            cursor_next = '0;
                            if (seq_ok && seen_reg[seq_idx])
                            begin
                                bk_re          = 1'b1;
                                cur_valid_next = 1'b1;
                                cur_seq_next   = seq_idx;
                                state_next     = S_SEL;
                            end
                            else
                            begin
                                cur_valid_next = 1'b0;
                                status_next    = STAT_NOT_FOUND;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (!cur_valid_reg)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                iv_re      = 1'b1;
                                pos_next   = req.query_position;
                                state_next = S_QCMP;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SEL:
            begin
                cur_base_next  = bk_rdata[BKW-1:CW];
                cur_count_next = bk_rdata[CW-1:0];
                state_next     = S_RESP;
            end
            S_QCMP:
            begin
                if (cursor_reg >= cur_count_reg)
                begin
                    state_next = S_RESP;
                end
                else if (pos_reg > iv_end)
                begin
                    cursor_next = CW'(cursor_reg + 1'b1);
                    iv_re       = 1'b1;
                end
                else
                begin
                    if (pos_reg >= iv_start)
                    begin
                        hit_next       = 1'b1;
                        hit_start_next = iv_start;
                        hit_end_next   = iv_end;
                        hit_slot_next  = slot_wide[SLOT_W-1:0];
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seen_reg       <= '0;
            total_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_seq_reg   <= '0;
            last_base_reg  <= '0;
            last_count_reg <= '0;
            last_lo_reg    <= '0;
            last_hi_reg    <= '0;
            cur_valid_reg  <= 1'b0;
            cur_seq_reg    <= '0;
            cur_base_reg   <= '0;
            cur_count_reg  <= '0;
            cursor_reg     <= '0;
            pos_reg        <= '0;
            status_reg     <= STAT_OK;
            hit_reg        <= 1'b0;
            hit_start_reg  <= '0;
            hit_end_reg    <= '0;
            hit_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            seen_reg       <= seen_next;
            total_reg      <= total_next;
            last_valid_reg <= last_valid_next;
            last_seq_reg   <= last_seq_next;
            last_base_reg  <= last_base_next;
            last_count_reg <= last_count_next;
            last_lo_reg    <= last_lo_next;
            last_hi_reg    <= last_hi_next;
            cur_valid_reg  <= cur_valid_next;
            cur_seq_reg    <= cur_seq_next;
            cur_base_reg   <= cur_base_next;
            cur_count_reg  <= cur_count_next;
            cursor_reg     <= cursor_next;
            pos_reg        <= pos_next;
            status_reg     <= status_next;
            hit_reg        <= hit_next;
            hit_start_reg  <= hit_start_next;
            hit_end_reg    <= hit_end_next;
            hit_slot_reg   <= hit_slot_next;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = (state_reg == S_RESP);
    assign rsp.status    = status_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.hit_start = hit_start_reg;
    assign rsp.hit_end   = hit_end_reg;
    assign rsp.hit_slot  = hit_slot_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while a response is pending");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && state_reg != S_SEL) |-> (cursor_reg <= cur_count_reg))
        else $error("cursor ran past the end of the current block");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg <= CW'(MAX_INTERVALS)) && (last_count_reg <= total_reg))
        else $error("interval store count out of range");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.status == STAT_OK))
        else $error("hit reported with an error status");
endmodule
